// File: design/psimp_pkg.sv
// ----------------------------------------------------------------------------
// psimp_pkg
// shared types and constants of the polyline simplifier
// ----------------------------------------------------------------------------
package psimp_pkg;

   localparam int unsigned FieldBits  = 12;
   localparam int unsigned IndexBits  = 6;
   localparam int unsigned StatusBits = 2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [15:0] TOL_RESET = 16'd32;

   // register byte addresses
   localparam logic [1:0] ADDR_TOLERANCE = 2'd0;

   typedef struct packed {
      logic [FieldBits-1:0] px;
      logic [FieldBits-1:0] py;
      logic                 final_point;
   } req_beat_type;

   typedef struct packed {
      logic [FieldBits-1:0]  kept_x;
      logic [FieldBits-1:0]  kept_y;
      logic [IndexBits-1:0]  source_index;
      logic                  end_of_run;
      logic [StatusBits-1:0] status;
   } rsp_beat_type;

endpackage

// File: design/psimp_mac.sv
// ----------------------------------------------------------------------------
// psimp_mac
// shared multiplier with accumulate, one product per cycle while enable is high, registered
// ----------------------------------------------------------------------------
module psimp_mac import psimp_pkg::*; #(
   parameter int unsigned W = 34
) (
   input  logic                  clock,
   input  logic                  clear,
   input  logic                  enable,
   input  logic                  subtract,
   input  logic signed [W/2:0]   op_a,
   input  logic signed [W/2:0]   op_b,
   output logic signed [W+1:0]   acc
);

   logic signed [W+1:0] acc_ff, acc_in;
   logic signed [W+1:0] prod;

   always_comb begin
      prod = (W+2)'(op_a * op_b);
      acc_in = acc_ff;
      if (enable) begin
         acc_in = (clear ? '0 : acc_ff) + (subtract ? -prod : prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: design/polyline_simplifier_top.sv
// ----------------------------------------------------------------------------
// polyline_simplifier_top
// ramer-douglas-peucker polyline simplifier with explicit segment stack
// ----------------------------------------------------------------------------
// Points load one per cycle (busy stays low) until a beat with final_point.
// Then busy rises while a sequencer walks the segment stack; every product
// goes through one shared multiply-accumulate unit. The tolerance is first
// squared once per line. A popped segment with no interior point is dropped
// after the stack read; otherwise the sequencer reads both end points and
// forms the chord and its squared length, then for each interior point reads
// it, forms two products and compares, then runs the split test and on a
// split pushes the two halves. Kept points then leave on rsp_valid in index
// order after the stack empties; the receiver cannot stall, so no output
// queue sits behind them.
// ----------------------------------------------------------------------------
module polyline_simplifier_top import psimp_pkg::*; #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_beat_type  req_beat,
   output logic          rsp_valid,
   output rsp_beat_type  rsp_beat,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [1:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned CW = FieldBits;
   localparam int unsigned NW = AW + 1;
   // cross product magnitude and squared chord bits
   localparam int unsigned MW = 2*CW + 1;
   // shared multiplier operand bits
   localparam int unsigned OW = 33;
   localparam int unsigned SW = 2*MW + 8;

   typedef enum logic [4:0] {
      S_LOAD, S_T2, S_T2_SAVE, S_POP, S_RD_A, S_RD_B, S_DX, S_L2A, S_L2B,
      S_RD_I, S_V, S_M1, S_M2, S_CMP, S_Q1, S_Q2, S_Q3, S_PUSH2,
      S_EMIT_RD, S_EMIT, S_ERR
   } state_type;

   state_type state_ff, state_in;

   // ---------------- configuration
   logic [15:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (psel && penable && pwrite && paddr == ADDR_TOLERANCE) begin
         tol_ff <= pwdata[15:0];
      end
   end
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_TOLERANCE) ? {16'd0, tol_ff} : 32'd0;

   // ---------------- memories
   logic [2*CW-1:0] pmem [MAX_POINTS];
   logic [2*CW-1:0] prd_ff;
   logic [AW-1:0]   prd_addr;
   logic [2*AW-1:0] smem [MAX_POINTS];
   logic [2*AW-1:0] srd_ff;
   logic            swr_en;
   logic [NW-1:0]   swr_addr;
   logic [2*AW-1:0] swr_data;
   logic [MAX_POINTS-1:0] keep_ff, keep_in;

   // ---------------- control registers
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [NW-1:0] top_ff, top_in;
   logic [AW-1:0] a_ff, a_in, b_ff, b_in, i_ff, i_in, best_ff, best_in;
   logic signed [CW:0] ax_ff, ax_in, ay_ff, ay_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [MW-1:0]   l2_ff, l2_in, bm_ff, bm_in;
   logic [SW-1:0]   lhs_ff, lhs_in;
   logic [31:0]     t2_ff, t2_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_beat_type    rsp_ff, rsp_in;

   // ---------------- shared unit
   logic                   m_clr, m_en, m_sub;
   logic signed [OW-1:0]   m_a, m_b;
   logic signed [2*OW-1:0] m_acc;

   psimp_mac #(.W(2*OW-2)) u_mac (
      .clock(clock), .clear(m_clr), .enable(m_en), .subtract(m_sub),
      .op_a(m_a), .op_b(m_b), .acc(m_acc)
   );

   logic signed [CW:0] rx, ry;
   assign rx = {1'b0, prd_ff[CW-1:0]};
   assign ry = {1'b0, prd_ff[2*CW-1:CW]};

   logic [2*OW-1:0] mag;
   assign mag = m_acc[2*OW-1] ? $unsigned(-m_acc) : $unsigned(m_acc);

   logic [NW-1:0] lastidx;
   assign lastidx = cnt_ff - NW'(1);

   logic load_fire;
   assign load_fire = start && !busy;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; ovf_in = ovf_ff; top_in = top_ff;
      a_in = a_ff; b_in = b_ff; i_in = i_ff; best_in = best_ff;
      ax_in = ax_ff; ay_in = ay_ff; dx_in = dx_ff; dy_in = dy_ff;
      vx_in = vx_ff; vy_in = vy_ff; l2_in = l2_ff; bm_in = bm_ff;
      lhs_in = lhs_ff; t2_in = t2_ff;
      keep_in = keep_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      prd_addr = i_ff;
      swr_en = 1'b0; swr_addr = top_ff; swr_data = {a_ff, b_ff};
      m_clr = 1'b1; m_en = 1'b0; m_sub = 1'b0;
      m_a = '0; m_b = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (load_fire) begin
               if (cnt_ff < NW'(MAX_POINTS)) begin
                  cnt_in = cnt_ff + NW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_beat.final_point) begin
                  if (cnt_in < NW'(2)) begin
                     state_in = S_ERR;
                  end else begin
                     keep_in[0] = 1'b1;
                     keep_in[AW'(cnt_in - NW'(1))] = 1'b1;
                     swr_en = 1'b1; swr_addr = '0;
                     swr_data = {AW'(0), AW'(cnt_in - NW'(1))};
                     top_in = NW'(1);
                     state_in = S_T2;
                  end
               end
            end
         end
         S_T2: begin
            m_en = 1'b1;
            m_a = OW'({1'b0, tol_ff}); m_b = OW'({1'b0, tol_ff});
            state_in = S_T2_SAVE;
         end
         S_T2_SAVE: begin
            t2_in = m_acc[31:0];
            state_in = S_POP;
         end
         S_POP: begin
            if (top_ff == '0) begin
               i_in = '0;
               state_in = S_EMIT_RD;
            end else begin
               top_in = top_ff - NW'(1);
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            a_in = srd_ff[2*AW-1:AW];
            b_in = srd_ff[AW-1:0];
            if ({1'b0, srd_ff[AW-1:0]} <= {1'b0, srd_ff[2*AW-1:AW]} + NW'(1)
                || {1'b0, srd_ff[AW-1:0]} >= cnt_ff) begin
               state_in = S_POP;
            end else begin
               prd_addr = srd_ff[2*AW-1:AW];
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            ax_in = rx; ay_in = ry;
            prd_addr = b_ff;
            state_in = S_DX;
         end
         S_DX: begin
            dx_in = rx - ax_ff; dy_in = ry - ay_ff;
            state_in = S_L2A;
         end
         S_L2A: begin
            m_en = 1'b1; m_a = OW'(dx_ff); m_b = OW'(dx_ff);
            state_in = S_L2B;
         end
         S_L2B: begin
            m_en = 1'b1; m_clr = 1'b0; m_a = OW'(dy_ff); m_b = OW'(dy_ff);
            i_in = a_ff + AW'(1);
            bm_in = '0; best_in = '0;
            state_in = S_RD_I;
         end
         S_RD_I: begin
            if (i_ff == a_ff + AW'(1)) begin
               l2_in = m_acc[MW-1:0];
            end
            prd_addr = i_ff;
            state_in = S_V;
         end
         S_V: begin
            vx_in = rx - ax_ff; vy_in = ry - ay_ff;
            state_in = S_M1;
         end
         S_M1: begin
            m_en = 1'b1;
            if (l2_ff != '0) begin
               m_a = OW'(dx_ff); m_b = OW'(vy_ff);
            end else begin
               m_a = OW'(vx_ff); m_b = OW'(vx_ff);
            end
            state_in = S_M2;
         end
         S_M2: begin
            m_en = 1'b1; m_clr = 1'b0;
            if (l2_ff != '0) begin
               m_sub = 1'b1; m_a = OW'(dy_ff); m_b = OW'(vx_ff);
            end else begin
               m_a = OW'(vy_ff); m_b = OW'(vy_ff);
            end
            state_in = S_CMP;
         end
         S_CMP: begin
            if (mag[MW-1:0] > bm_ff) begin
               bm_in = mag[MW-1:0]; best_in = i_ff;
            end
            if (i_ff + AW'(1) == b_ff) begin
               state_in = S_Q1;
            end else begin
               i_in = i_ff + AW'(1);
               state_in = S_RD_I;
            end
         end
         S_Q1: begin
            if (bm_ff == '0) begin
               state_in = S_POP;
            end else if (l2_ff == '0) begin
               lhs_in = SW'({bm_ff, 8'd0});
               state_in = S_Q3;
            end else begin
               m_en = 1'b1;
               m_a = OW'(bm_ff); m_b = OW'(bm_ff);
               state_in = S_Q2;
            end
         end
         S_Q2: begin
            lhs_in = {m_acc[2*MW-1:0], 8'd0};
            m_en = 1'b1;
            m_a = OW'(t2_ff); m_b = OW'(l2_ff);
            state_in = S_Q3;
         end
         S_Q3: begin
            if (lhs_ff > ((l2_ff == '0) ? SW'(t2_ff) : m_acc[SW-1:0])) begin
               keep_in[best_ff] = 1'b1;
               if (top_ff < NW'(MAX_POINTS)) begin
                  swr_en = 1'b1; swr_addr = top_ff; swr_data = {best_ff, b_ff};
                  top_in = top_ff + NW'(1);
               end
               state_in = S_PUSH2;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH2: begin
            if (top_ff < NW'(MAX_POINTS)) begin
               swr_en = 1'b1; swr_addr = top_ff; swr_data = {a_ff, best_ff};
               top_in = top_ff + NW'(1);
            end
            state_in = S_POP;
         end
         S_EMIT_RD: begin
            prd_addr = i_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (keep_ff[i_ff]) begin
               rsp_valid_in = 1'b1;
               rsp_in.kept_x = prd_ff[CW-1:0];
               rsp_in.kept_y = prd_ff[2*CW-1:CW];
               rsp_in.source_index = IndexBits'(i_ff);
               rsp_in.end_of_run = ({1'b0, i_ff} == lastidx);
               rsp_in.status = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
            end
            if ({1'b0, i_ff} == lastidx) begin
               keep_in = '0; cnt_in = '0; ovf_in = 1'b0; top_in = '0;
               state_in = S_LOAD;
            end else begin
               i_in = i_ff + AW'(1);
               prd_addr = i_in;
               state_in = S_EMIT;
            end
         end
         S_ERR: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.end_of_run = 1'b1;
            rsp_in.status = STATUS_TOO_FEW;
            cnt_in = '0; ovf_in = 1'b0;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_fire && cnt_ff < NW'(MAX_POINTS)) begin
         pmem[AW'(cnt_ff)] <= {req_beat.py, req_beat.px};
      end
      prd_ff <= pmem[prd_addr];
      if (swr_en) begin
         smem[AW'(swr_addr)] <= swr_data;
      end
      srd_ff <= smem[AW'(top_in)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0; ovf_ff <= 1'b0; top_ff <= '0;
         keep_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; ovf_ff <= ovf_in; top_ff <= top_in;
         keep_ff <= keep_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; i_ff <= i_in; best_ff <= best_in;
      ax_ff <= ax_in; ay_ff <= ay_in; dx_ff <= dx_in; dy_ff <= dy_in;
      vx_ff <= vx_in; vy_ff <= vy_in; l2_ff <= l2_in; bm_ff <= bm_in;
      lhs_ff <= lhs_in; t2_ff <= t2_in; rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;

endmodule

// File: design/psimp_checker.sv
// ----------------------------------------------------------------------------
// psimp_checker
// port-level checks of the polyline simplifier
// ----------------------------------------------------------------------------
module psimp_checker import psimp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_beat_type rsp_beat,
   input logic         pready
);

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.status != 2'd3)
      else $error("bad status");

   a_err_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.status == STATUS_TOO_FEW |-> rsp_beat.end_of_run)
      else $error("error beat not last");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("not idle after reset");

endmodule

bind polyline_simplifier_top psimp_checker u_psimp_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_beat(rsp_beat), .pready(pready)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// polyline simplifier testbench
// drives polylines through the command port under several tolerance
// settings and checks every kept point against an in-bench simplifier
// ----------------------------------------------------------------------------
module testbench import psimp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY  = 64;
   localparam int unsigned LIMIT     = 3000000;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_beat_type  req_beat;
   logic          rsp_valid;
   rsp_beat_type  rsp_beat;
   logic          psel;
   logic          penable;
   logic          pwrite;
   logic [1:0]    paddr;
   logic [31:0]   pwdata;
   logic [31:0]   prdata;
   logic          pready;

   polyline_simplifier_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_beat(req_beat), .rsp_valid(rsp_valid), .rsp_beat(rsp_beat),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   req_beat_type  point_queue[$];
   rsp_beat_type  kept_queue[$];
   int unsigned   gap_percent;
   int unsigned   errors;
   int unsigned   cycles;

   // predictor state
   logic [15:0]   tol_copy;
   logic [11:0]   line_x [CAPACITY];
   logic [11:0]   line_y [CAPACITY];
   logic          keep   [CAPACITY];
   int unsigned   line_count;
   logic          line_overflow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // split a segment list the way the block does, then queue kept points
   task automatic simplify_line();
      int unsigned  seg_a [$];
      int unsigned  seg_b [$];
      int unsigned  a, b, best;
      longint       dx, dy, vx, vy, c, m, bestm, l2;
      logic [127:0] lhs, rhs;
      logic         split;
      rsp_beat_type r;
      for (int k = 0; k < CAPACITY; k++) keep[k] = 1'b0;
      keep[0] = 1'b1;
      keep[line_count-1] = 1'b1;
      seg_a = {seg_a, 0};
      seg_b = {seg_b, line_count - 1};
      while (seg_a.size() > 0) begin
         a = seg_a.pop_back();
         b = seg_b.pop_back();
         if (b <= a + 1 || b >= line_count) continue;
         dx = longint'(line_x[b]) - longint'(line_x[a]);
         dy = longint'(line_y[b]) - longint'(line_y[a]);
         l2 = dx * dx + dy * dy;
         bestm = 0;
         best = 0;
         for (int unsigned i = a + 1; i < b; i++) begin
            vx = longint'(line_x[i]) - longint'(line_x[a]);
            vy = longint'(line_y[i]) - longint'(line_y[a]);
            if (l2 != 0) begin
               c = dx * vy - dy * vx;
               m = (c < 0) ? -c : c;
            end else begin
               m = vx * vx + vy * vy;
            end
            if (m > bestm) begin
               bestm = m;
               best = i;
            end
         end
         if (bestm == 0) continue;
         if (l2 != 0) begin
            lhs = 128'(bestm) * 128'(bestm) * 128'd256;
            rhs = 128'(tol_copy) * 128'(tol_copy) * 128'(l2);
         end else begin
            lhs = 128'(bestm) * 128'd256;
            rhs = 128'(tol_copy) * 128'(tol_copy);
         end
         split = lhs > rhs;
         if (split) begin
            keep[best] = 1'b1;
            if (seg_a.size() < CAPACITY) begin
               seg_a = {seg_a, best};
               seg_b = {seg_b, b};
            end
            if (seg_a.size() < CAPACITY) begin
               seg_a = {seg_a, a};
               seg_b = {seg_b, best};
            end
         end
      end
      for (int unsigned i = 0; i < line_count; i++) begin
         if (keep[i]) begin
            r.kept_x       = line_x[i];
            r.kept_y       = line_y[i];
            r.source_index = IndexBits'(i);
            r.end_of_run   = (i == line_count - 1);
            r.status       = line_overflow ? STATUS_OVERFLOW : STATUS_OK;
            kept_queue = {kept_queue, r};
         end
      end
   endtask

   task automatic take_point(req_beat_type p);
      rsp_beat_type r;
      if (line_count < CAPACITY) begin
         line_x[line_count] = p.px;
         line_y[line_count] = p.py;
         line_count++;
      end else begin
         line_overflow = 1'b1;
      end
      if (p.final_point) begin
         if (line_count < 2) begin
            r = '0;
            r.end_of_run = 1'b1;
            r.status = STATUS_TOO_FEW;
            kept_queue = {kept_queue, r};
         end else begin
            simplify_line();
         end
         line_count = 0;
         line_overflow = 1'b0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) take_point(req_beat);
         if (start && busy) begin
            start <= 1'b1;
         end else if (point_queue.size() > 0 && $urandom_range(99) >= gap_percent) begin
            start <= 1'b1;
            req_beat <= point_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid) begin
         if (kept_queue.size() == 0) begin
            $display("%0t: unexpected kept point %p", $time, rsp_beat);
            errors++;
         end else begin
            want = kept_queue.pop_front();
            if (rsp_beat !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_beat);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_beat_type mk(int unsigned x, int unsigned y, bit last);
      req_beat_type p;
      p.px = 12'(x);
      p.py = 12'(y);
      p.final_point = last;
      return p;
   endfunction

   // shape 0 random, 1 noisy straight line, 2 all on one spot, 3 closed loop
   task automatic add_line(int unsigned n, int unsigned shape);
      int unsigned x0, y0, x1, y1, noise;
      int          ox, oy;
      req_beat_type p;
      x0 = $urandom_range(4095);
      y0 = $urandom_range(4095);
      x1 = $urandom_range(4095);
      y1 = $urandom_range(4095);
      noise = $urandom_range(0, 1) ? $urandom_range(3) : $urandom_range(200);
      for (int unsigned i = 0; i < n; i++) begin
         ox = int'($urandom_range(2 * noise)) - int'(noise);
         oy = int'($urandom_range(2 * noise)) - int'(noise);
         case (shape)
            0: p = mk($urandom, $urandom, i == n - 1);
            1: p = mk(x0 + (int'(x1) - int'(x0)) * int'(i) / int'(n) + ox,
                      y0 + (int'(y1) - int'(y0)) * int'(i) / int'(n) + oy,
                      i == n - 1);
            2: p = mk(x0, y0, i == n - 1);
            default: p = mk((i == n - 1) ? x0 : x0 + ox + 8 * i,
                            (i == n - 1) ? y0 : y0 + oy, i == n - 1);
         endcase
         point_queue = {point_queue, p};
      end
   endtask

   task automatic csr_write(logic [15:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_TOLERANCE;
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tol_copy = value;
   endtask

   task automatic drain();
      while (point_queue.size() != 0 || start || kept_queue.size() != 0 || busy)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int unsigned fed, n, pick;
      logic [15:0] tol_set [4];
      int unsigned gaps [4];
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_beat = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      gap_percent = 13;
      tol_copy = TOL_RESET;
      line_count = 0;
      line_overflow = 1'b0;
      tol_set = '{16'd0, 16'(24 + $urandom_range(200)), 16'hffff, 16'd16};
      gaps = '{13, 13, 53, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed beats at reset tolerance
      point_queue = {point_queue, mk(0, 0, 1), mk(4095, 4095, 0), mk(0, 0, 1)};
      point_queue = {point_queue, mk(0, 0, 0), mk(4095, 0, 0), mk(4095, 4095, 0),
                     mk(0, 4095, 1)};
      point_queue = {point_queue, mk(10, 10, 0), mk(20, 20, 0), mk(30, 30, 1)};
      point_queue = {point_queue, mk(100, 100, 0), mk(103, 100, 0), mk(100, 100, 1)};
      point_queue = {point_queue, mk(0, 0, 0), mk(1, 2, 0), mk(2, 0, 0), mk(4, 0, 1)};
      drain();
      add_line(70, 1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(tol_set[ph]);
         gap_percent = gaps[ph];
         fed = 0;
         while (fed < 100) begin
            pick = $urandom_range(99);
            if (pick < 5) n = 1;
            else if (pick < 10) n = $urandom_range(65, 68);
            else if (pick < 18) n = $urandom_range(17, 64);
            else n = $urandom_range(2, 16);
            add_line(n, ($urandom_range(9) < 6) ? 1 : $urandom_range(3));
            fed += n;
         end
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: polyline_simplifier_top.f
design/psimp_pkg.sv
design/psimp_mac.sv
design/polyline_simplifier_top.sv
design/psimp_checker.sv
tb/testbench.sv
